[src/hpd_pkg.sv]
// shared types, constants and reset values of the heartbeat pulse detector
`default_nettype none

package hpd_pkg;

  // fixed field widths
  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned LEVEL_W    = 10;
  localparam int unsigned TIME_W     = 13;
  localparam int unsigned PERIOD_W   = 4;
  localparam int unsigned HOLD_W     = 12;
  localparam int unsigned BPM_W      = 16;
  localparam int unsigned CFG_W      = 12;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned S_TDATA_W  = 16;
  localparam int unsigned M_TDATA_W  = 56;
  localparam int unsigned M_FIELDS_W = 3 + BPM_W + TIME_W + 2 * LEVEL_W;

  // parameter defaults
  localparam int unsigned HISTORY_DEPTH_DEF = 10;
  localparam int unsigned SAMPLE_BITS_DEF   = 10;

  // reset values of registers and state
  localparam logic [PERIOD_W-1:0] PERIOD_RST   = 4'd2;
  localparam logic [HOLD_W-1:0]   HOLDOFF_RST  = 12'd250;
  localparam logic [HOLD_W-1:0]   TIMEOUT_RST  = 12'd2500;
  localparam logic [LEVEL_W-1:0]  TO_THR_RST   = 10'd520;
  localparam logic [LEVEL_W-1:0]  TO_LVL_RST   = 10'd510;
  localparam logic [TIME_W-1:0]   INTERVAL_RST = 13'd600;
  localparam logic [TIME_W-1:0]   BLANK_RST    = 13'd360;
  localparam logic [LEVEL_W-1:0]  LEVEL_RST    = 10'd500;
  localparam logic [LEVEL_W-1:0]  THR_RST      = 10'd510;
  localparam logic [TIME_W-1:0]   ELAPSED_MAX  = 13'd8191;
  localparam logic [BPM_W-1:0]    BPM_FULL     = 16'd60000;

  // divide by five through a reciprocal, exact for all 13-bit values
  localparam logic [15:0]  RECIP5       = 16'd52429;
  localparam int unsigned  RECIP5_SHIFT = 18;
  localparam int unsigned  QUOT5_W      = 11;
  localparam int unsigned  PROD5_W      = TIME_W + 16;

  // configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_PERIOD  = 3'd0,
    CFG_HOLDOFF = 3'd1,
    CFG_TIMEOUT = 3'd2,
    CFG_TO_THR  = 3'd3,
    CFG_TO_LVL  = 3'd4
  } hpd_cfg_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_sample;
    logic step;
    logic div5;
    logic blank_load;
    logic mean_load;
    logic div_start;
    logic quo_load;
    logic out_load;
  } hpd_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic beat;
    logic rate_upd;
    logic div_done;
  } hpd_sts_t;

endpackage

`default_nettype wire

[src/hpd_div.sv]
// iterative restoring divider, one quotient bit per cycle
`default_nettype none

module hpd_div #(
  parameter int unsigned WIDTH = 17
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [WIDTH-1:0] dividend_i,
  input  wire logic [WIDTH-1:0] divisor_i,
  output logic                  done_o,
  output logic [WIDTH-1:0]      quotient_o
);

  localparam int unsigned CNT_W = $clog2(WIDTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WIDTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  logic             run_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [WIDTH-1:0] rem_q;
  logic [WIDTH-1:0] quo_q;
  logic [WIDTH-1:0] dvs_q;
  logic [WIDTH:0]   shifted;
  logic [WIDTH+1:0] diff;

  // trial subtraction of the divisor from the shifted remainder
  assign shifted = {rem_q, quo_q[WIDTH-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};

  // control: run counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CNT_FULL;
      end else if (run_q) begin
        cnt_q <= cnt_q - CNT_ONE;
        if (cnt_q == CNT_ONE) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath: remainder and quotient shift
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      if (!diff[WIDTH+1]) begin
        rem_q <= diff[WIDTH-1:0];
        quo_q <= {quo_q[WIDTH-2:0], 1'b1};
      end else begin
        rem_q <= shifted[WIDTH-1:0];
        quo_q <= {quo_q[WIDTH-2:0], 1'b0};
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

[src/hpd_datapath.sv]
// datapath: configuration, beat detection state, interval history and rate
`default_nettype none

module hpd_datapath import hpd_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [CFG_W-1:0]      cfg_wdata_i,
  input  wire logic [SAMPLE_W-1:0]   sample_i,
  input  wire hpd_cmd_t              cmd_i,
  output hpd_sts_t                   sts_o,
  output logic [M_TDATA_W-1:0]       m_data_o
);

  localparam int unsigned PTR_W    = $clog2(HISTORY_DEPTH);
  localparam int unsigned SUM_W    = TIME_W + $clog2(HISTORY_DEPTH);
  localparam int unsigned DIV_W    = BPM_W;
  localparam int unsigned USE_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((64'd1 << USE_BITS) - 64'd1);
  localparam logic [PTR_W-1:0]    PTR_LAST    = PTR_W'(HISTORY_DEPTH - 1);
  localparam logic [PTR_W-1:0]    PTR_ONE     = PTR_W'(1);
  localparam logic [SUM_W-1:0]    DEPTH_S     = SUM_W'(HISTORY_DEPTH);

  // history mean through a rounded-up reciprocal of the depth, exact for any sum
  localparam int unsigned RECIPD_SHIFT = SUM_W + $clog2(HISTORY_DEPTH);
  localparam int unsigned RECIPD_W     = SUM_W + 1;
  localparam int unsigned PRODD_W      = SUM_W + RECIPD_W;
  localparam logic [RECIPD_W-1:0] RECIPD =
    RECIPD_W'(((64'd1 << RECIPD_SHIFT) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH));

  // configuration registers
  logic [PERIOD_W-1:0] period_q;
  logic [HOLD_W-1:0]   holdoff_q;
  logic [HOLD_W-1:0]   timeout_q;
  logic [LEVEL_W-1:0]  to_thr_q;
  logic [LEVEL_W-1:0]  to_lvl_q;

  // detector state
  logic [LEVEL_W-1:0]  sample_q;
  logic [TIME_W-1:0]   elapsed_q, elapsed_d;
  logic [TIME_W-1:0]   interval_q, interval_d;
  logic [TIME_W-1:0]   blank_q;
  logic [LEVEL_W-1:0]  peak_q, peak_d;
  logic [LEVEL_W-1:0]  trough_q, trough_d;
  logic [LEVEL_W-1:0]  thr_q, thr_d;
  logic [LEVEL_W-1:0]  amp_q, amp_d;
  logic                pulse_q, pulse_d;
  logic                first_q, first_d;
  logic                second_q, second_d;
  logic                beat_q;
  logic                upd_q;
  logic [BPM_W-1:0]    bpm_q;
  logic [TIME_W-1:0]   mean_q;
  logic [QUOT5_W-1:0]  quot5_q;
  logic [M_TDATA_W-1:0] m_data_q;

  // interval history as a ring with a running sum
  logic [TIME_W-1:0]   hist_q [HISTORY_DEPTH];
  logic [PTR_W-1:0]    ptr_q;
  logic [SUM_W-1:0]    sum_q;

  // step logic
  logic [TIME_W:0]     elapsed_sum;
  logic [TIME_W-1:0]   n;
  logic                below, above, past_blank;
  logic [LEVEL_W-1:0]  peak1, trough1, amp_end, thr_end;
  logic                beat, skip, rate_upd, beat_end, timeout;
  logic [SUM_W-1:0]    seed_sum, roll_sum;

  // divider and reciprocals
  logic [DIV_W-1:0]    div_dividend, div_divisor, div_quo;
  logic                div_done;
  logic [PROD5_W-1:0]  prod5;
  logic [PRODD_W-1:0]  prodd;

  // elapsed time with saturation
  assign elapsed_sum = {1'b0, elapsed_q} + (TIME_W + 1)'(period_q);
  assign n = elapsed_sum[TIME_W] ? ELAPSED_MAX : elapsed_sum[TIME_W-1:0];

  // comparisons against threshold and blanking window
  assign below      = sample_q < thr_q;
  assign above      = sample_q > thr_q;
  assign past_blank = n > blank_q;

  assign trough1 = (below && past_blank && (sample_q < trough_q)) ? sample_q : trough_q;
  assign peak1   = (above && (sample_q > peak_q)) ? sample_q : peak_q;

  // beat, discarded first beat, beat end and timeout
  assign beat     = (n > {1'b0, holdoff_q}) && above && !pulse_q && past_blank;
  assign skip     = beat && first_q;
  assign rate_upd = beat && !first_q;
  assign beat_end = !skip && below && pulse_q;
  assign timeout  = !skip && (n > {1'b0, timeout_q});

  assign amp_end = (peak1 >= trough1) ? (peak1 - trough1) : '0;
  assign thr_end = trough1 + (amp_end >> 1);

  // history sums: seeded with a full ring, else oldest out and newest in
  assign seed_sum = SUM_W'(n) * DEPTH_S;
  assign roll_sum = sum_q - SUM_W'(hist_q[ptr_q]) + SUM_W'(n);

  // next state of the detector
  always_comb begin
    elapsed_d  = n;
    interval_d = interval_q;
    pulse_d    = pulse_q;
    first_d    = first_q;
    second_d   = second_q;
    peak_d     = peak1;
    trough_d   = trough1;
    thr_d      = thr_q;
    amp_d      = amp_q;
    if (beat) begin
      pulse_d    = 1'b1;
      interval_d = n;
      elapsed_d  = '0;
      first_d    = 1'b0;
      second_d   = first_q;
    end
    if (beat_end) begin
      pulse_d  = 1'b0;
      amp_d    = amp_end;
      thr_d    = thr_end;
      peak_d   = thr_end;
      trough_d = thr_end;
    end
    if (timeout) begin
      thr_d     = to_thr_q;
      peak_d    = to_lvl_q;
      trough_d  = to_lvl_q;
      elapsed_d = '0;
      first_d   = 1'b1;
      second_d  = 1'b0;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q  <= PERIOD_RST;
      holdoff_q <= HOLDOFF_RST;
      timeout_q <= TIMEOUT_RST;
      to_thr_q  <= TO_THR_RST;
      to_lvl_q  <= TO_LVL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_PERIOD:  period_q  <= cfg_wdata_i[PERIOD_W-1:0];
        CFG_HOLDOFF: holdoff_q <= cfg_wdata_i[HOLD_W-1:0];
        CFG_TIMEOUT: timeout_q <= cfg_wdata_i[HOLD_W-1:0];
        CFG_TO_THR:  to_thr_q  <= cfg_wdata_i[LEVEL_W-1:0];
        CFG_TO_LVL:  to_lvl_q  <= cfg_wdata_i[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // detector state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q  <= '0;
      interval_q <= INTERVAL_RST;
      blank_q    <= BLANK_RST;
      peak_q     <= LEVEL_RST;
      trough_q   <= LEVEL_RST;
      thr_q      <= THR_RST;
      amp_q      <= '0;
      pulse_q    <= 1'b0;
      first_q    <= 1'b1;
      second_q   <= 1'b0;
      beat_q     <= 1'b0;
      upd_q      <= 1'b0;
      bpm_q      <= '0;
      ptr_q      <= '0;
    end else begin
      if (cmd_i.step) begin
        elapsed_q  <= elapsed_d;
        interval_q <= interval_d;
        peak_q     <= peak_d;
        trough_q   <= trough_d;
        thr_q      <= thr_d;
        amp_q      <= amp_d;
        pulse_q    <= pulse_d;
        first_q    <= first_d;
        second_q   <= second_d;
        beat_q     <= beat;
        upd_q      <= rate_upd;
        if (rate_upd && !second_q) begin
          ptr_q <= (ptr_q == PTR_LAST) ? '0 : ptr_q + PTR_ONE;
        end
      end
      if (cmd_i.blank_load) begin
        blank_q <= TIME_W'(quot5_q) + TIME_W'({quot5_q, 1'b0});
      end
      if (cmd_i.quo_load) begin
        bpm_q <= (mean_q == '0) ? BPM_FULL : div_quo[BPM_W-1:0];
      end
    end
  end

  // sample capture, history ring and payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sample) begin
      sample_q <= sample_i & SAMPLE_MASK;
    end
    if (cmd_i.step && rate_upd) begin
      if (second_q) begin
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
          hist_q[i] <= n;
        end
        sum_q <= seed_sum;
      end else begin
        hist_q[ptr_q] <= n;
        sum_q         <= roll_sum;
      end
    end
    if (cmd_i.div5) begin
      quot5_q <= prod5[RECIP5_SHIFT +: QUOT5_W];
    end
    if (cmd_i.mean_load) begin
      mean_q <= prodd[RECIPD_SHIFT +: TIME_W];
    end
    if (cmd_i.out_load) begin
      m_data_q <= {(M_TDATA_W - M_FIELDS_W)'(0), amp_q, thr_q, interval_q, bpm_q,
                   upd_q, beat_q, pulse_q};
    end
  end

  // blanking window: interval / 5 by reciprocal, times 3 in the next cycle
  assign prod5 = PROD5_W'(interval_q) * PROD5_W'(RECIP5);

  // history mean: running sum times the depth reciprocal
  assign prodd = PRODD_W'(sum_q) * PRODD_W'(RECIPD);

  // divider forms the rate from the registered mean
  assign div_dividend = DIV_W'(BPM_FULL);
  assign div_divisor  = DIV_W'(mean_q);

  hpd_div #(
    .WIDTH (DIV_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign sts_o.beat     = beat_q;
  assign sts_o.rate_upd = upd_q;
  assign sts_o.div_done = div_done;
  assign m_data_o       = m_data_q;

endmodule

`default_nettype wire

[src/hpd_ctrl.sv]
// controller: sequences one sample through step, blanking, mean, divide and output
`default_nettype none

module hpd_ctrl import hpd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     s_tvalid_i,
  output logic          s_tready_o,
  output logic          m_tvalid_o,
  input  wire logic     m_tready_i,
  input  wire hpd_sts_t sts_i,
  output hpd_cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_STEP,
    S_DECIDE,
    S_DIV5,
    S_BLANK,
    S_MEAN,
    S_BPM_GO,
    S_BPM,
    S_EMIT
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  // commands decoded from the state
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE:    cmd_o.load_sample = s_tvalid_i;
      S_STEP:    cmd_o.step        = 1'b1;
      S_DECIDE:  ;
      S_DIV5:    cmd_o.div5        = 1'b1;
      S_BLANK:   cmd_o.blank_load  = 1'b1;
      S_MEAN:    cmd_o.mean_load   = 1'b1;
      S_BPM_GO:  cmd_o.div_start   = 1'b1;
      S_BPM:     cmd_o.quo_load    = sts_i.div_done;
      S_EMIT:    cmd_o.out_load    = !out_valid_q || m_tready_i;
      default: ;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE:    if (s_tvalid_i) state_q <= S_STEP;
        S_STEP:    state_q <= S_DECIDE;
        S_DECIDE:  state_q <= sts_i.beat ? S_DIV5 : S_EMIT;
        S_DIV5:    state_q <= S_BLANK;
        S_BLANK:   state_q <= sts_i.rate_upd ? S_MEAN : S_EMIT;
        S_MEAN:    state_q <= S_BPM_GO;
        S_BPM_GO:  state_q <= S_BPM;
        S_BPM:     if (sts_i.div_done) state_q <= S_EMIT;
        S_EMIT:    if (cmd_o.out_load) state_q <= S_IDLE;
        default:   state_q <= S_IDLE;
      endcase
    end
  end

  assign s_tready_o = (state_q == S_IDLE);
  assign m_tvalid_o = out_valid_q;

  // divider finishes only while a divide is awaited
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == S_BPM))
    else $error("divider done outside a divide wait");

  // a result is never loaded over one that was not taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || m_tready_i))
    else $error("output register overwritten");

  // an accepted beat is always followed by the detector step
  a_step_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o) |=> cmd_o.step)
    else $error("accepted sample not stepped");

endmodule

`default_nettype wire

[src/heartbeat_pulse_detector_unit.sv]
// top level of the heartbeat pulse detector: controller plus datapath
//
// Usage: one ADC sample per input beat on the s_axis channel (sample_code in
// s_axis_tdata[9:0]); for every sample exactly one result beat leaves on the
// m_axis channel with beat flag, rate, interval, threshold and amplitude.
// Configuration registers are written through cfg_we_i/cfg_addr_i/cfg_wdata_i
// while no sample is in flight; indexes beyond the register list are ignored.
// A sample without a detected beat passes the detector step and the decision
// on to the output register; a detected beat adds the blanking window (interval
// divided by five through a reciprocal multiply); a beat that updates the rate
// adds the history mean (sum times a reciprocal of the depth) and the bit-serial
// divider that forms 60000 / mean (DIV_W = 16). One sample is worked on at a
// time; the next is taken the cycle after its predecessor has moved to the
// output register.
// A stalled receiver holds the result in the output register; the next sample
// is still accepted and processed, and waits at the end until the register
// is free. Reset restores the register defaults and detector state; the
// interval history has no reset and is seeded on the second beat.
`default_nettype none

module heartbeat_pulse_detector_unit import hpd_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [CFG_W-1:0]      cfg_wdata_i,
  // sample input
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,  // [9:0] sample_code
  // result output
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]       m_axis_tdata   // [0] pulse_active, [1] beat_onset,
                                                    // [2] bpm_updated,
                                                    // [18:3] beats_per_minute,
                                                    // [31:19] interbeat_ms,
                                                    // [41:32] threshold_level,
                                                    // [51:42] amplitude
);

  hpd_cmd_t cmd;
  hpd_sts_t sts;

  hpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hpd_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (s_axis_tdata[SAMPLE_W-1:0]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .m_data_o    (m_axis_tdata)
  );

endmodule

`default_nettype wire

[verif/hpd_checker.sv]
// scoreboard of the heartbeat pulse detector: predicts each sample's result and compares
module hpd_checker import hpd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // [9:0] sample_code
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [M_TDATA_W-1:0]  m_axis_tdata,   // [0] pulse_active, [1] beat_onset,
                                                // [2] bpm_updated, [18:3] beats_per_minute,
                                                // [31:19] interbeat_ms, [41:32] threshold_level,
                                                // [51:42] amplitude
  output int                    fail_cnt_o,
  output int                    pending_o,
  output int                    beat_cnt_o,
  output int                    rate_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HIST  = HISTORY_DEPTH_DEF;
  localparam int unsigned SUM_W = 17;
  localparam int unsigned SHOWN = 10;

  typedef struct packed {
    logic               pulse;
    logic               onset;
    logic               upd;
    logic [BPM_W-1:0]   bpm;
    logic [TIME_W-1:0]  ibi;
    logic [LEVEL_W-1:0] thr;
    logic [LEVEL_W-1:0] amp;
  } pulse_result_t;

  // register copies
  logic [PERIOD_W-1:0] period_ms;
  logic [HOLD_W-1:0]   holdoff_ms;
  logic [HOLD_W-1:0]   timeout_ms;
  logic [LEVEL_W-1:0]  to_thr;
  logic [LEVEL_W-1:0]  to_lvl;

  // detector state
  logic [TIME_W-1:0]  elapsed;
  logic [TIME_W-1:0]  interval;
  logic [LEVEL_W-1:0] peak;
  logic [LEVEL_W-1:0] trough;
  logic [LEVEL_W-1:0] thr;
  logic [LEVEL_W-1:0] amp;
  logic               pulse;
  logic               first_beat;
  logic               second_beat;
  logic [TIME_W-1:0]  ibi_hist [HIST];
  logic [SUM_W-1:0]   hist_sum;
  logic [BPM_W-1:0]   bpm;

  pulse_result_t expected_q [$];
  int            mism_cnt;

  // one sample through the detector: trough, peak, onset, beat end, timeout
  task automatic predict_sample(input logic [SAMPLE_W-1:0] code, output pulse_result_t res);
    logic [TIME_W:0]    sum_t;
    logic [TIME_W-1:0]  now_ms;
    logic [TIME_W-1:0]  blank_ms;
    logic [SUM_W-1:0]   mean;
    logic               onset;
    logic               upd;
    logic               fresh;
    int                 k;
    onset = 1'b0;
    upd   = 1'b0;
    fresh = 1'b0;
    sum_t  = {1'b0, elapsed} + (TIME_W+1)'(period_ms);
    now_ms = (sum_t > (TIME_W+1)'(ELAPSED_MAX)) ? ELAPSED_MAX : sum_t[TIME_W-1:0];
    elapsed  = now_ms;
    blank_ms = (interval / 13'd5) * 13'd3;
    // trough only counts once the notch blanking window has passed
    if (code < thr && now_ms > blank_ms && code < trough) trough = code;
    if (code > thr && code > peak) peak = code;
    // beat onset
    if (now_ms > TIME_W'(holdoff_ms) && code > thr && !pulse && now_ms > blank_ms) begin
      pulse    = 1'b1;
      onset    = 1'b1;
      interval = now_ms;
      elapsed  = '0;
      if (second_beat) begin
        second_beat = 1'b0;
        for (k = 0; k < HIST; k++) ibi_hist[k] = now_ms;
      end
      if (first_beat) begin
        // first beat after a restart is thrown away
        first_beat  = 1'b0;
        second_beat = 1'b1;
        fresh       = 1'b1;
      end else begin
        hist_sum = '0;
        for (k = 0; k < HIST - 1; k++) begin
          ibi_hist[k] = ibi_hist[k+1];
          hist_sum += ibi_hist[k];
        end
        ibi_hist[HIST-1] = now_ms;
        hist_sum += now_ms;
        mean = hist_sum / SUM_W'(HIST);
        bpm  = (mean == '0) ? BPM_FULL : BPM_W'(32'(BPM_FULL) / 32'(mean));
        upd  = 1'b1;
      end
    end
    if (!fresh) begin
      // beat end: new threshold halfway up the last swing
      if (code < thr && pulse) begin
        pulse  = 1'b0;
        amp    = (peak >= trough) ? peak - trough : '0;
        thr    = trough + (amp >> 1);
        peak   = thr;
        trough = thr;
      end
      // timeout uses the elapsed time from before any onset on this sample
      if (now_ms > TIME_W'(timeout_ms)) begin
        thr         = to_thr;
        peak        = to_lvl;
        trough      = to_lvl;
        elapsed     = '0;
        first_beat  = 1'b1;
        second_beat = 1'b0;
      end
    end
    res = '{pulse: pulse, onset: onset, upd: upd, bpm: bpm, ibi: interval, thr: thr, amp: amp};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pulse_result_t act;
    pulse_result_t exp_r;
    if (!rst_ni) begin
      period_ms   = PERIOD_RST;
      holdoff_ms  = HOLDOFF_RST;
      timeout_ms  = TIMEOUT_RST;
      to_thr      = TO_THR_RST;
      to_lvl      = TO_LVL_RST;
      elapsed     = '0;
      interval    = INTERVAL_RST;
      peak        = LEVEL_RST;
      trough      = LEVEL_RST;
      thr         = THR_RST;
      amp         = '0;
      pulse       = 1'b0;
      first_beat  = 1'b1;
      second_beat = 1'b0;
      bpm         = '0;
      hist_sum    = '0;
      foreach (ibi_hist[i]) ibi_hist[i] = '0;
      expected_q.delete();
      mism_cnt    = 0;
      fail_cnt_o  = 0;
      pending_o   = 0;
      beat_cnt_o  = 0;
      rate_cnt_o  = 0;
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_PERIOD:  period_ms  = cfg_wdata_i[PERIOD_W-1:0];
          CFG_HOLDOFF: holdoff_ms = cfg_wdata_i[HOLD_W-1:0];
          CFG_TIMEOUT: timeout_ms = cfg_wdata_i[HOLD_W-1:0];
          CFG_TO_THR:  to_thr     = cfg_wdata_i[LEVEL_W-1:0];
          CFG_TO_LVL:  to_lvl     = cfg_wdata_i[LEVEL_W-1:0];
          default: ;
        endcase
      end
      // result beat against the oldest expectation
      if (m_axis_tvalid && m_axis_tready) begin
        act.pulse = m_axis_tdata[0];
        act.onset = m_axis_tdata[1];
        act.upd   = m_axis_tdata[2];
        act.bpm   = m_axis_tdata[18:3];
        act.ibi   = m_axis_tdata[31:19];
        act.thr   = m_axis_tdata[41:32];
        act.amp   = m_axis_tdata[51:42];
        if (expected_q.size() == 0) begin
          fail_cnt_o++;
          if (mism_cnt < SHOWN) $display("%t: result beat with nothing expected", $time);
          mism_cnt++;
        end else begin
          exp_r = expected_q.pop_front();
          if (act.pulse !== exp_r.pulse || act.onset !== exp_r.onset ||
              act.upd !== exp_r.upd || act.bpm !== exp_r.bpm || act.ibi !== exp_r.ibi ||
              act.thr !== exp_r.thr || act.amp !== exp_r.amp) begin
            fail_cnt_o++;
            if (mism_cnt < SHOWN) begin
              $display("%t: mismatch exp pulse=%0d onset=%0d upd=%0d bpm=%0d ibi=%0d thr=%0d amp=%0d",
                       $time, exp_r.pulse, exp_r.onset, exp_r.upd, exp_r.bpm, exp_r.ibi,
                       exp_r.thr, exp_r.amp);
              $display("%t:          got pulse=%0d onset=%0d upd=%0d bpm=%0d ibi=%0d thr=%0d amp=%0d",
                       $time, act.pulse, act.onset, act.upd, act.bpm, act.ibi, act.thr, act.amp);
            end
            mism_cnt++;
          end
        end
      end
      // sample beat: predict its result
      if (s_axis_tvalid && s_axis_tready) begin
        predict_sample(s_axis_tdata[SAMPLE_W-1:0], exp_r);
        if (exp_r.onset) beat_cnt_o++;
        if (exp_r.upd) rate_cnt_o++;
        expected_q.push_back(exp_r);
      end
      pending_o = expected_q.size();
    end
  end

endmodule

[verif/tb_top.sv]
// testbench top of the heartbeat pulse detector: clock, reset, stimulus and verdict
module tb_top;
  import hpd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 3'd7;   // index with no register behind it
  localparam int unsigned HOLD_CYCLES = 400;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [CFG_W-1:0]      cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata;    // [9:0] sample_code
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [M_TDATA_W-1:0]  m_axis_tdata;    // [0] pulse_active, [1] beat_onset, [2] bpm_updated,
                                          // [18:3] beats_per_minute, [31:19] interbeat_ms,
                                          // [41:32] threshold_level, [51:42] amplitude

  int fail_cnt;
  int pending;
  int beat_cnt;
  int rate_cnt;
  int src_idle_pct;
  int dst_idle_pct;
  int hold_asked;
  int hold_seen;
  int hold_left;
  int sample_cnt;
  int setting_cnt;

  heartbeat_pulse_detector_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  hpd_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_cnt_o    (fail_cnt),
    .pending_o     (pending),
    .beat_cnt_o    (beat_cnt),
    .rate_cnt_o    (rate_cnt)
  );

  // clock
  always #6 clk_i = ~clk_i;

  // run limit
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver: random stalls plus long hold-offs on request
  initial begin
    m_axis_tready = 1'b0;
    hold_seen     = 0;
    hold_left     = 0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
      end
    end
  end

  // one sample beat, with random idle cycles ahead of it
  task automatic send_sample(input logic [SAMPLE_W-1:0] code);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_TDATA_W'(code);
    do @(posedge clk_i); while (!s_axis_tready);
    sample_cnt++;
  endtask

  // stop offering and wait until every result has been taken
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // write all five registers and the spare index, back to back
  task automatic write_regs(input logic [CFG_W-1:0] period, input logic [CFG_W-1:0] holdoff,
                            input logic [CFG_W-1:0] timeout, input logic [CFG_W-1:0] to_thr,
                            input logic [CFG_W-1:0] to_lvl);
    logic [CFG_ADDR_W-1:0] idx [6];
    logic [CFG_W-1:0]      val [6];
    int                    i;
    idx = '{CFG_PERIOD, CFG_HOLDOFF, CFG_TIMEOUT, CFG_TO_THR, CFG_TO_LVL, CFG_SPARE};
    val = '{period, holdoff, timeout, to_thr, to_lvl, CFG_W'($urandom)};
    for (i = 0; i < 6; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_addr_i  <= idx[i];
      cfg_wdata_i <= val[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    setting_cnt++;
  endtask

  // heartbeat-like waveform: a short high part per beat, low rest, some noise
  task automatic run_waveform(input int n_items, input int beat_len);
    int left;
    int len;
    int lo;
    int hi;
    int hi_len;
    int pos;
    int base;
    int swing;
    int code;
    left = n_items;
    lo = (beat_len * 3 / 4 < 2) ? 2 : beat_len * 3 / 4;
    hi = (beat_len * 5 / 4 < lo) ? lo : beat_len * 5 / 4;
    while (left > 0) begin
      // an occasional broken beat of random length
      len    = ($urandom_range(0, 99) < 8) ? $urandom_range(1, hi) : $urandom_range(lo, hi);
      hi_len = $urandom_range(1, (len >= 3) ? len / 3 : 1);
      base   = $urandom_range(0, 300);
      swing  = $urandom_range(600, 1023 - base);
      for (pos = 0; pos < len && left > 0; pos++) begin
        if ($urandom_range(0, 99) < 10) code = $urandom_range(0, 1023);
        else if (pos < hi_len) code = base + swing - $urandom_range(0, swing / 8);
        else code = base + $urandom_range(0, swing / 8);
        send_sample(code[SAMPLE_W-1:0]);
        left--;
      end
    end
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] period, input logic [CFG_W-1:0] holdoff,
                           input logic [CFG_W-1:0] timeout, input logic [CFG_W-1:0] to_thr,
                           input logic [CFG_W-1:0] to_lvl, input int n_items, input int beat_len);
    drain();
    write_regs(period, holdoff, timeout, to_thr, to_lvl);
    run_waveform(n_items, beat_len);
  endtask

  // random register setting with a beat length that fits it
  task automatic run_random_phase(input int n_items);
    int per;
    int hold;
    int tmo;
    per  = $urandom_range(1, 15);
    hold = $urandom_range(0, 800);
    tmo  = $urandom_range(hold + 200, 4095);
    run_phase(CFG_W'(per), CFG_W'(hold), CFG_W'(tmo), CFG_W'($urandom_range(0, 1023)),
              CFG_W'($urandom_range(0, 1023)), n_items,
              (hold + $urandom_range(50, 600)) / per);
  endtask

  // stimulus
  initial begin
    logic [SAMPLE_W-1:0] edge_codes [12];
    int i;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = '0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    hold_asked    = 0;
    sample_cnt    = 0;
    setting_cnt   = 0;
    src_idle_pct  = 18;
    dst_idle_pct  = 72;
    edge_codes = '{10'd0, 10'd1023, 10'h155, 10'h2AA, 10'd1, 10'd1022,
                   10'd511, 10'd512, 10'd0, 10'd1023, 10'd700, 10'd100};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings, extreme codes
    for (i = 0; i < 12; i++) send_sample(edge_codes[i]);

    // default settings with the period field at its maximum, a long receiver hold-off, then faster beats
    run_phase(12'hFFF, 12'd250, 12'd2500, 12'd520, 12'd510, 0, 55);
    hold_asked++;
    run_waveform(200, 55);
    run_phase(12'd10, 12'd60, 12'd600, CFG_W'($urandom), CFG_W'($urandom), 200, 12);
    // period of one, zero holdoff, longest timeout
    run_phase(12'd1, 12'd0, 12'hFFF, 12'd0, 12'd0, 150, 6);

    src_idle_pct = 72;
    dst_idle_pct = 18;
    // onset can only come with a timeout on the same sample
    run_phase(12'd15, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 120, 20);
    // timeout on every sample, thresholds at both ends
    run_phase(12'd15, 12'd0, 12'd0, 12'd0, 12'd0, 60, 4);
    run_phase(12'd15, 12'd0, 12'd0, 12'h3FF, 12'h3FF, 40, 4);
    // period field written as zero
    run_phase(12'h010, 12'd100, 12'd1500, 12'd520, 12'd510, 40, 10);
    run_random_phase(100);

    src_idle_pct = 0;
    dst_idle_pct = 0;
    run_random_phase(100);
    run_random_phase(100);
    run_phase(12'd5, 12'd100, 12'd1500, 12'd520, 12'd510, 0, 40);
    hold_asked++;
    run_waveform(180, 40);

    drain();
    repeat (60) @(posedge clk_i);
    $display("covered %0d samples under %0d register settings", sample_cnt, setting_cnt + 1);
    $display("%0d beat onsets, %0d rate updates, %0d results outstanding",
             beat_cnt, rate_cnt, pending);
    if (fail_cnt == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
